FILE: src/pvli_pkg.sv
// Shared constants, types and helpers for the priority voice list.
`timescale 1ns / 1ps

package pvli_pkg;

    localparam int LIST_DEPTH  = 16;
    localparam int VOICE_COUNT = 16;
    localparam int IDX_W       = $clog2(LIST_DEPTH);
    localparam int CNT_W       = $clog2(LIST_DEPTH + 1);
    localparam int IDX_XW      = (IDX_W > 4) ? IDX_W : 4;
    localparam int CNT_XW      = (CNT_W > 5) ? CNT_W : 5;

    localparam logic [7:0] NO_SOURCE = 8'hFF;
    localparam logic [4:0] NO_VOICE  = 5'd16;

    localparam logic OP_CLEAR  = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    typedef enum logic [2:0] {
        ST_INSERTED = 3'd0,
        ST_APPENDED = 3'd1,
        ST_DROPPED  = 3'd2,
        ST_EXPELLED = 3'd3,
        ST_CLEARED  = 3'd4
    } t_status;

    typedef struct packed {
        logic load;    // capture the input item
        logic scan;    // register the compare result
        logic commit;  // update the list and the output register
    } t_cmd;

    function automatic logic [3:0] to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_XW-1:0] t;
        t = IDX_XW'(idx);
        return t[3:0];
    endfunction

    function automatic logic [4:0] to_cnt(input logic [CNT_W-1:0] cnt);
        logic [CNT_XW-1:0] t;
        t = CNT_XW'(cnt);
        return t[4:0];
    endfunction

endpackage

FILE: src/pvli_ctrl.sv
// Controller: sequences capture, scan and commit of one item and owns output valid.
`timescale 1ns / 1ps

module pvli_ctrl
    import pvli_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   commit_ok;

    // commit only when the output register is free or being emptied
    assign commit_ok   = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = commit_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    if (commit_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (commit_ok) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

FILE: src/pvli_dp.sv
// Datapath: the sorted slot row, the voice owner map and the result register.
`timescale 1ns / 1ps

module pvli_dp
    import pvli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic               i_op,
    input  logic [7:0]         i_source_id,
    input  logic signed [31:0] i_priority_key,
    input  logic [4:0]         i_voice,
    input  logic               i_oneshot_done,
    output logic [2:0]         o_status,
    output logic [3:0]         o_position,
    output logic               o_evicted_valid,
    output logic [7:0]         o_evicted_id,
    output logic [4:0]         o_list_count
);

    // captured item
    logic               r_op;
    logic [7:0]         r_src;
    logic signed [31:0] r_key;
    logic [4:0]         r_voice;
    logic               r_done;

    // slot row
    logic [7:0]         r_slot_source [LIST_DEPTH];
    logic signed [31:0] r_slot_key    [LIST_DEPTH];
    logic [4:0]         r_slot_voice  [LIST_DEPTH];
    logic [7:0]         r_voice_owner [VOICE_COUNT];
    logic [CNT_W-1:0]   r_count;

    // scan result
    logic               r_hit;
    logic [IDX_W-1:0]   r_idx;
    logic               r_full;

    // result register
    t_status            r_status;
    logic [3:0]         r_position;
    logic               r_ev_valid;
    logic [7:0]         r_ev_id;
    logic [4:0]         r_list_count;

    logic               n_hit;
    logic [IDX_W-1:0]   n_idx;
    logic [IDX_W-1:0]   ins_pos;
    logic               do_clear;
    logic               do_place;
    logic               do_shift;
    logic               do_drop;
    logic [CNT_W-1:0]   n_count;
    logic [4:0]         last_voice;

    // every cell compares in parallel; the first cell at or below the key wins
    always_comb begin
        n_hit = 1'b0;
        n_idx = '0;
        for (int k = LIST_DEPTH - 1; k >= 0; k--) begin
            if ((CNT_W'(k) < r_count) && (r_key >= r_slot_key[k])) begin
                n_hit = 1'b1;
                n_idx = IDX_W'(k);
            end
        end
    end

    assign do_clear   = i_cmd.commit && (r_op == OP_CLEAR);
    assign do_place   = i_cmd.commit && (r_op == OP_INSERT) && !r_done && (r_hit || !r_full);
    assign do_shift   = do_place && r_hit;
    assign do_drop    = i_cmd.commit && (r_op == OP_INSERT) && !r_done && !r_hit && r_full;
    assign ins_pos    = r_hit ? r_idx : r_count[IDX_W-1:0];
    assign last_voice = r_slot_voice[LIST_DEPTH-1];

    always_comb begin
        n_count = r_count;
        if (do_clear) begin
            n_count = '0;
        end else if (do_place && !r_full) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_src   <= i_source_id;
            r_key   <= i_priority_key;
            r_voice <= i_voice;
            r_done  <= i_oneshot_done;
        end
        if (i_cmd.scan) begin
            r_hit  <= n_hit;
            r_idx  <= n_idx;
            r_full <= (r_count == CNT_W'(LIST_DEPTH));
        end
    end

    // keys have no defined reset value
    always_ff @(posedge i_clk) begin
        if (do_place) begin
            for (int k = 1; k < LIST_DEPTH; k++) begin
                if (do_shift && (IDX_W'(k) > r_idx)) begin
                    r_slot_key[k] <= r_slot_key[k-1];
                end
            end
            r_slot_key[ins_pos] <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int k = 0; k < LIST_DEPTH; k++) begin
                r_slot_source[k] <= NO_SOURCE;
                r_slot_voice[k]  <= NO_VOICE;
            end
            for (int k = 0; k < VOICE_COUNT; k++) begin
                r_voice_owner[k] <= NO_SOURCE;
            end
        end else begin
            r_count <= n_count;
            if (do_clear) begin
                for (int k = 0; k < LIST_DEPTH; k++) begin
                    r_slot_source[k] <= NO_SOURCE;
                    r_slot_voice[k]  <= NO_VOICE;
                end
                for (int k = 0; k < VOICE_COUNT; k++) begin
                    r_voice_owner[k] <= NO_SOURCE;
                end
            end else if (do_place) begin
                // release the evicted voice first; the new owner overrides it
                if (do_shift && r_full && (last_voice < 5'(VOICE_COUNT))) begin
                    r_voice_owner[last_voice[3:0]] <= NO_SOURCE;
                end
                for (int k = 1; k < LIST_DEPTH; k++) begin
                    if (do_shift && (IDX_W'(k) > r_idx)) begin
                        r_slot_source[k] <= r_slot_source[k-1];
                        r_slot_voice[k]  <= r_slot_voice[k-1];
                    end
                end
                r_slot_source[ins_pos] <= r_src;
                r_slot_voice[ins_pos]  <= r_voice;
                if (r_voice < 5'(VOICE_COUNT)) begin
                    r_voice_owner[r_voice[3:0]] <= r_src;
                end
            end else if (do_drop) begin
                if (r_voice < 5'(VOICE_COUNT)) begin
                    r_voice_owner[r_voice[3:0]] <= NO_SOURCE;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_position   <= 4'd0;
            r_ev_valid   <= 1'b0;
            r_ev_id      <= NO_SOURCE;
            r_list_count <= to_cnt(n_count);
            if (r_op == OP_CLEAR) begin
                r_status <= ST_CLEARED;
            end else if (r_done) begin
                r_status <= ST_EXPELLED;
            end else if (r_hit) begin
                r_status   <= ST_INSERTED;
                r_position <= to_pos(r_idx);
                if (r_full) begin
                    r_ev_valid <= 1'b1;
                    r_ev_id    <= r_slot_source[LIST_DEPTH-1];
                end
            end else if (!r_full) begin
                r_status   <= ST_APPENDED;
                r_position <= to_pos(r_count[IDX_W-1:0]);
            end else begin
                r_status <= ST_DROPPED;
            end
        end
    end

    assign o_status        = r_status;
    assign o_position      = r_position;
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_id    = r_ev_id;
    assign o_list_count    = r_list_count;

endmodule

FILE: src/priority_voice_list_insert_core.sv
// Top level of the priority voice list: controller plus datapath.
//
// Keeps a per-frame list of sound sources sorted by priority key, highest first,
// and a map from voice number to owning source.
// Input (i_in_valid / o_in_ready): op 0 clears the list and the map, op 1 inserts
// a source before the first entry with an equal or lower key, or appends it.
// Output channel (o_out_valid / i_out_ready): exactly one result per item, with
// status, placed position, evicted source and the list count after the item.
// Sequence: an accepted item is captured, then scanned by one compare per slot,
// and committed once the output register is free; its result is then valid.
// The capture-scan-commit sequence of the controller handles items one at a time.
// The result sits in an output register, so the next item is accepted and
// scanned while it waits; if the receiver stalls, commit holds until the
// register is free and the input stays not ready.
// Reset (synchronous, active low) empties the list and the voice map and
// drops any pending result.
`timescale 1ns / 1ps

module priority_voice_list_insert_core
    import pvli_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic [7:0]         i_source_id,
    input  logic signed [31:0] i_priority_key,
    input  logic [4:0]         i_voice,
    input  logic               i_oneshot_done,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [2:0]         o_status,
    output logic [3:0]         o_position,
    output logic               o_evicted_valid,
    output logic [7:0]         o_evicted_id,
    output logic [4:0]         o_list_count
);

    t_cmd cmd;

    pvli_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd)
    );

    pvli_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_source_id     (i_source_id),
        .i_priority_key  (i_priority_key),
        .i_voice         (i_voice),
        .i_oneshot_done  (i_oneshot_done),
        .o_status        (o_status),
        .o_position      (o_position),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_id    (o_evicted_id),
        .o_list_count    (o_list_count)
    );

endmodule

FILE: src/pvli_checker.sv
// Port-level checks of the priority voice list, bound to the top level.
`timescale 1ns / 1ps

module pvli_checker
    import pvli_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic [2:0]         o_status,
    input logic               o_evicted_valid,
    input logic [7:0]         o_evicted_id,
    input logic [4:0]         o_list_count
);

    // one item at a time: no new item right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted back to back");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_CLEARED)) |-> (o_list_count == 5'd0))
        else $error("cleared result with nonzero count");

    a_evict_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_evicted_valid) |-> (o_status == ST_INSERTED))
        else $error("eviction without insert");

    a_no_evict_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_evicted_valid) |-> (o_evicted_id == NO_SOURCE))
        else $error("evicted id without eviction");

    a_placed_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status == ST_INSERTED) || (o_status == ST_APPENDED)))
        |-> (o_list_count != 5'd0))
        else $error("placed source but list empty");

endmodule

bind priority_voice_list_insert_core pvli_checker u_pvli_checker (.*);
